### rtl/l2d_pkg.sv
// Shared constants and types for the stored-vector L2 distance block.
`default_nettype none

package l2d_pkg;

  // Store geometry.
  localparam int MAX_DIM     = 128;
  localparam int MAX_POINTS  = 1024;
  localparam int STORE_DEPTH = MAX_DIM * MAX_POINTS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int ROW_W   = 10;
  localparam int IDX_W   = 7;
  localparam int VAL_W   = 16;
  localparam int DIM_W   = 8;
  localparam int PCNT_W  = 11;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int SQ_W    = 32;
  localparam int SUM_W   = 40;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int DIST_W  = 20;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'd1;

  // Opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};

  typedef struct packed {
    logic start;
    logic take;
  } l2d_root_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } l2d_root_sts_t;

endpackage

`default_nettype wire

### rtl/l2d_isqrt.sv
// Iterative floor square root, one result bit per cycle.
`default_nettype none

module l2d_isqrt
  import l2d_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire l2d_root_ctl_t       ctl,
  input  wire logic [SUM_W-1:0]    radicand,
  output l2d_root_sts_t            sts,
  output logic [ROOT_W-1:0]        root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  x_r, x_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // The remainder never exceeds twice the partial root, so its top two bits
  // are clear before each shift.
  assign rem_sh = {rem_r[REM_W-3:0], x_r[SUM_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          state_nxt = ST_RUN;
          cnt_nxt   = CNT_W'(ROOT_W - 1);
          x_nxt     = radicand;
          rem_nxt   = '0;
          root_nxt  = '0;
        end
      end
      ST_RUN: begin
        x_nxt = {x_r[SUM_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DONE: begin
        if (ctl.take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign sts.busy = (state_r != ST_IDLE);
  assign sts.done = (state_r == ST_DONE);
  assign root     = root_r;

endmodule

`default_nettype wire

### rtl/stored_vector_l2_distance_top.sv
// Top level of the stored-vector L2 distance block.
//
//  Channel  Direction  Beat carries
//  in_      slave      tdata: row, element_index, element_value; tuser: opcode;
//                      tlast: last_element
//  out_     master     tdata: distance; tuser: invalid
//  cfg_     write      cfg_index selects dimension or point_count
//
// Write and query beats are accepted one per cycle. A query element passes a
// store read, a subtract, a square and an accumulate stage. On the last
// element the accumulate stage launches the bit-serial square root, and the
// output register loads the result from the root unit once it is done and
// the result side is free. A last query beat is held off while an earlier
// last element is still in the pipeline or in the root unit. The store is not
// cleared after reset; the sum and all valid bits are.
`default_nettype none

module stored_vector_l2_distance_top
  import l2d_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration.
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  // Input stream.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // row, element_index, element_value, pad
  input  wire logic                   in_tuser,   // opcode
  input  wire logic                   in_tlast,
  // Result stream.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // distance, pad
  output logic                        out_tuser   // invalid
);

  // Configuration registers.
  logic [DIM_W-1:0]  dimension_r;
  logic [PCNT_W-1:0] point_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dimension_r   <= '0;
      point_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIMENSION:   dimension_r   <= cfg_wdata[DIM_W-1:0];
        CFG_POINT_COUNT: point_count_r <= cfg_wdata[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input beat decode.
  logic [ROW_W-1:0]        in_row;
  logic [IDX_W-1:0]        in_idx;
  logic signed [VAL_W-1:0] in_val;
  logic                    in_store;
  logic [ADDR_W-1:0]       in_addr;
  logic                    accept;
  logic                    is_query;
  logic                    last_busy;

  assign in_row   = in_tdata[ROW_W-1:0];
  assign in_idx   = in_tdata[ROW_W +: IDX_W];
  assign in_val   = in_tdata[ROW_W+IDX_W +: VAL_W];
  assign in_store = (32'(in_row) < MAX_POINTS) && (32'(in_idx) < MAX_DIM);
  assign in_addr  = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_idx);
  assign is_query = (in_tuser == OP_QUERY);

  // Only a last query beat has to wait for the previous result to clear.
  assign in_tready = !(in_tvalid && is_query && in_tlast && last_busy);
  assign accept    = in_tvalid && in_tready;

  // Vector store: one port, written by write beats, read by query beats.
  logic [VAL_W-1:0] store_mem [STORE_DEPTH];
  logic [VAL_W-1:0] mem_q_r;

  always_ff @(posedge clk) begin
    if (accept && in_store) begin
      if (in_tuser == OP_WRITE) begin
        store_mem[in_addr] <= in_val;
      end else begin
        mem_q_r <= store_mem[in_addr];
      end
    end
  end

  // Stage 1: store data arriving.
  logic                    s1_vld_r, s1_use_r, s1_last_r, s1_inv_r;
  logic signed [VAL_W-1:0] s1_val_r;
  // Stage 2: difference.
  logic                     s2_vld_r, s2_use_r, s2_last_r, s2_inv_r;
  logic signed [DIFF_W-1:0] s2_diff_r;
  // Stage 3: square.
  logic                  s3_vld_r, s3_use_r, s3_last_r, s3_inv_r;
  logic [SQ_W-1:0]       s3_sq_r;

  logic                      s1_inv_nxt;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [2*DIFF_W-1:0] sq_full;

  assign s1_inv_nxt = (PCNT_W'(in_row) >= point_count_r) || (32'(in_row) >= MAX_POINTS)
                      || (dimension_r == '0);
  assign diff       = DIFF_W'(s1_val_r) - DIFF_W'($signed(mem_q_r));
  assign sq_full    = s2_diff_r * s2_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept && is_query;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
    s1_use_r  <= in_store && (DIM_W'(in_idx) < dimension_r);
    s1_last_r <= in_tlast;
    s1_inv_r  <= s1_inv_nxt;
    s1_val_r  <= in_val;
    s2_use_r  <= s1_use_r;
    s2_last_r <= s1_last_r;
    s2_inv_r  <= s1_inv_r;
    s2_diff_r <= diff;
    s3_use_r  <= s2_use_r;
    s3_last_r <= s2_last_r;
    s3_inv_r  <= s2_inv_r;
    s3_sq_r   <= sq_full[SQ_W-1:0];
  end

  // Stage 4: saturating accumulate, and launch of the root on the last element.
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_new;
  logic             root_inv_r;
  l2d_root_ctl_t    root_ctl;
  l2d_root_sts_t    root_sts;
  logic [ROOT_W-1:0] root_val;

  assign sum_wide = {1'b0, sum_r} + (SUM_W+1)'(s3_use_r ? s3_sq_r : '0);
  assign sum_new  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (s3_vld_r) begin
      sum_r <= s3_last_r ? '0 : sum_new;
    end
    if (root_ctl.start) begin
      root_inv_r <= s3_inv_r;
    end
  end

  assign root_ctl.start = s3_vld_r && s3_last_r;
  assign root_ctl.take  = root_sts.done && (!out_tvalid || out_tready);

  assign last_busy = (s1_vld_r && s1_last_r) || (s2_vld_r && s2_last_r)
                     || (s3_vld_r && s3_last_r) || root_sts.busy;

  l2d_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (root_ctl),
    .radicand (sum_new),
    .sts      (root_sts),
    .root     (root_val)
  );

  // Output register.
  logic              out_vld_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (root_ctl.take) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (root_ctl.take) begin
      out_dist_r <= root_inv_r ? DIST_ONES : DIST_W'(root_val);
      out_inv_r  <= root_inv_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'(out_dist_r);
  assign out_tuser  = out_inv_r;

endmodule

`default_nettype wire

### rtl/l2d_chk.sv
// Port-level checks for the stored-vector L2 distance block, bound to the top level.
`default_nettype none

module l2d_chk
  import l2d_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // An invalid result always carries the all-ones distance.
  a_inv_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[DIST_W-1:0] == DIST_ONES)
    else $error("invalid result without all-ones distance");

  // Reset leaves no result pending.
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The pad bits above the distance stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:DIST_W] == '0)
    else $error("nonzero pad bits in result");

endmodule

bind stored_vector_l2_distance_top l2d_chk u_l2d_chk (.*);

`default_nettype wire
